@@ rtl/lpsd_pkg.sv @@
package lpsd_pkg;

  localparam logic [7:0] CMD_POINT_COLOR = 8'h20;
  localparam logic [7:0] CMD_POINT_HOLD  = 8'h21;

  localparam logic [3:0] DAC_A_CMD = 4'b0111;
  localparam logic [3:0] DAC_B_CMD = 4'b1111;

  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MONOCHROME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES  = 1'd1;

  typedef enum logic [5:0] {
    PH_CMD   = 6'b000001,
    PH_X     = 6'b000010,
    PH_Y     = 6'b000100,
    PH_LOW   = 6'b001000,
    PH_RG    = 6'b010000,
    PH_BLUE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] dac_a_word;
    logic [15:0] dac_b_word;
    logic [6:0]  color_first_byte;
    logic [7:0]  color_second_byte;
    logic        status_led;
  } out_item_t;

  typedef struct packed {
    logic monochrome;
    logic swap_axes;
  } cfg_t;

endpackage

@@ rtl/lpsd_point_fmt.sv @@
module lpsd_point_fmt (
  input  logic [7:0]   x_high,
  input  logic [7:0]   y_high,
  input  logic [7:0]   xy_low_nibbles,
  input  logic [7:0]   red_green_byte,
  input  logic [7:0]   blue_byte,
  input  lpsd_pkg::cfg_t cfg,
  output logic [15:0]  dac_a_word,
  output logic [15:0]  dac_b_word,
  output logic [6:0]   color_first_byte,
  output logic [7:0]   color_second_byte
);
  import lpsd_pkg::*;

  logic [11:0] x_word;
  logic [11:0] y_word;
  logic [3:0]  red;
  logic [3:0]  green;
  logic [3:0]  blue;
  logic [3:0]  peak;
  logic [3:0]  red_out;
  logic [3:0]  green_out;
  logic [3:0]  blue_out;

  always_comb begin
    x_word = {x_high, xy_low_nibbles[3:0]};
    y_word = {y_high, xy_low_nibbles[7:4]};
    red    = red_green_byte[7:4];
    green  = red_green_byte[3:0];
    blue   = blue_byte[7:4];

    peak = red;
    if (green > peak) begin
      peak = green;
    end
    if (blue > peak) begin
      peak = blue;
    end

    red_out   = cfg.monochrome ? peak : red;
    green_out = cfg.monochrome ? peak : green;
    blue_out  = cfg.monochrome ? peak : blue;

    if (cfg.swap_axes) begin
      dac_a_word = {DAC_A_CMD, x_word};
      dac_b_word = {DAC_B_CMD, y_word};
    end else begin
      dac_a_word = {DAC_A_CMD, y_word};
      dac_b_word = {DAC_B_CMD, x_word};
    end

    color_first_byte  = {(blue_out != 4'd0), (green_out != 4'd0), (red_out != 4'd0), blue_out};
    color_second_byte = {green_out, red_out};
  end

endmodule

@@ rtl/laser_point_stream_decoder_core.sv @@
// Laser point stream decoder.
// Bytes of the point stream arrive on the in_valid/in_ready channel, one item
// per byte, with frame_end marking the last byte of a frame. Each completed
// point leaves as one item on the out_valid/out_ready channel carrying both
// DAC command words, the two color shift bytes and the status LED bit.
// The cfg channel writes the monochrome and swap_axes registers; it is always
// ready and should only be used while no point is in flight.
// An accepted byte is held in an input register and parsed there; the byte
// that finishes a point loads it into the output register, where it is
// visible, as soon as that register is empty or its point is being taken.
// Throughput is one byte per cycle unless a finished point stalls; parsing is
// a one-hot phase update and the point packing is nibble compares and muxes.
// When the receiver stalls, a finished point waits in the output register and
// one more byte can still be taken into the input register; bytes that do not
// complete a point keep flowing through the parser.
// Reset clears the parser to command position, the stored point bytes, the
// point counter and both configuration registers; both channels come up empty.
module laser_point_stream_decoder_core #(
  parameter int unsigned LED_ON_POINTS = 500,
  parameter int unsigned LED_PERIOD    = 1000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lpsd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lpsd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic                                cfg_data
);
  import lpsd_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic                 hold_colors;
  logic [7:0]           x_high;
  logic [7:0]           y_high;
  logic [7:0]           xy_low_nibbles;
  logic [7:0]           red_green_byte;
  logic [7:0]           blue_byte;
  logic [COUNT_W-1:0]   point_counter;
  logic [COUNT_W-1:0]   point_counter_next;
  logic [COUNT_W:0]     count_inc;
  logic                 led;
  cfg_t                 cfg;

  logic                 stage_valid;
  in_item_t             stage_item;
  logic                 emit;
  logic                 stage_go;

  logic [7:0]           low_eff;
  logic [7:0]           blue_eff;
  logic [15:0]          dac_a;
  logic [15:0]          dac_b;
  logic [6:0]           color_first;
  logic [7:0]           color_second;

  assign cfg_ready = 1'b1;

  assign emit     = stage_valid && (((phase == PH_LOW) && hold_colors) || (phase == PH_BLUE));
  assign stage_go = stage_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !stage_valid || stage_go;

  // The byte that completes a point takes part in it before it is stored.
  assign low_eff  = (phase == PH_LOW)  ? stage_item.data_byte : xy_low_nibbles;
  assign blue_eff = (phase == PH_BLUE) ? stage_item.data_byte : blue_byte;

  always_comb begin
    count_inc = {1'b0, point_counter} + {{COUNT_W{1'b0}}, 1'b1};
    led = (count_inc < (COUNT_W+1)'(LED_ON_POINTS));
    point_counter_next = (count_inc > (COUNT_W+1)'(LED_PERIOD)) ? '0 : count_inc[COUNT_W-1:0];
  end

  always_comb begin
    case (phase)
      PH_X:    phase_next = PH_Y;
      PH_Y:    phase_next = PH_LOW;
      PH_LOW:  phase_next = hold_colors ? PH_CMD : PH_RG;
      PH_RG:   phase_next = PH_BLUE;
      PH_BLUE: phase_next = PH_CMD;
      default: begin
        if ((stage_item.data_byte == CMD_POINT_COLOR) ||
            (stage_item.data_byte == CMD_POINT_HOLD)) begin
          phase_next = PH_X;
        end else begin
          phase_next = PH_CMD;
        end
      end
    endcase
    if (stage_item.frame_end) begin
      phase_next = PH_CMD;
    end
  end

  lpsd_point_fmt u_fmt (
    .x_high            (x_high),
    .y_high            (y_high),
    .xy_low_nibbles    (low_eff),
    .red_green_byte    (red_green_byte),
    .blue_byte         (blue_eff),
    .cfg               (cfg),
    .dac_a_word        (dac_a),
    .dac_b_word        (dac_b),
    .color_first_byte  (color_first),
    .color_second_byte (color_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MONOCHROME: cfg.monochrome <= cfg_data;
        REG_SWAP_AXES:  cfg.swap_axes  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      hold_colors    <= 1'b0;
      x_high         <= '0;
      y_high         <= '0;
      xy_low_nibbles <= '0;
      red_green_byte <= '0;
      blue_byte      <= '0;
      point_counter  <= '0;
    end else if (stage_go) begin
      phase <= phase_next;
      case (phase)
        PH_X:    x_high         <= stage_item.data_byte;
        PH_Y:    y_high         <= stage_item.data_byte;
        PH_LOW:  xy_low_nibbles <= stage_item.data_byte;
        PH_RG:   red_green_byte <= stage_item.data_byte;
        PH_BLUE: blue_byte      <= stage_item.data_byte;
        default: begin
          if ((stage_item.data_byte == CMD_POINT_COLOR) ||
              (stage_item.data_byte == CMD_POINT_HOLD)) begin
            hold_colors <= (stage_item.data_byte == CMD_POINT_HOLD);
          end
        end
      endcase
      if (emit) begin
        point_counter <= point_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (stage_go && emit) begin
      out_data.dac_a_word        <= dac_a;
      out_data.dac_b_word        <= dac_b;
      out_data.color_first_byte  <= color_first;
      out_data.color_second_byte <= color_second;
      out_data.status_led        <= led;
    end
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("parser phase lost its one-hot code");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    (stage_go && emit) |=> out_valid)
    else $error("completed point did not reach the output register");

  a_frame_end_resets: assert property (@(posedge clk) disable iff (rst)
    (stage_go && stage_item.frame_end) |=> (phase == PH_CMD))
    else $error("parser not in command position after frame end");

  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, point_counter} <= (COUNT_W+1)'(LED_PERIOD)))
    else $error("point counter beyond its period");

  a_stall_only_on_emit: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !stage_go) |-> (emit && out_valid && !out_ready))
    else $error("input stage stalled without a waiting result");

endmodule

@@ verif/laser_point_stream_decoder_core_test.sv @@
module laser_point_stream_decoder_core_test;
  import lpsd_pkg::*;

  localparam int unsigned LED_ON_POINTS = 500;
  localparam int unsigned LED_PERIOD    = 1000;
  localparam int unsigned DRAIN_CYCLES  = 8;

  // Shadow of the decoder: parser, stored point bytes, point counter and registers.
  class point_scoreboard;
    phase_t     phase;
    logic       hold_colors;
    logic [7:0] x_high;
    logic [7:0] y_high;
    logic [7:0] xy_low;
    logic [7:0] red_green;
    logic [7:0] blue;
    logic [9:0] point_count;
    logic       monochrome;
    logic       swap_axes;
    out_item_t  pending_points[$];
    int         mismatches;
    int         points;
    int         checked;
    int         wraps;

    function new();
      phase       = PH_CMD;
      hold_colors = 1'b0;
      x_high      = '0;
      y_high      = '0;
      xy_low      = '0;
      red_green   = '0;
      blue        = '0;
      point_count = '0;
      monochrome  = 1'b0;
      swap_axes   = 1'b0;
      mismatches  = 0;
      points      = 0;
      checked     = 0;
      wraps       = 0;
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic value);
      case (idx)
        REG_MONOCHROME: monochrome = value;
        REG_SWAP_AXES:  swap_axes = value;
        default: ;
      endcase
    endfunction

    function void push_point();
      logic [11:0] x_axis;
      logic [11:0] y_axis;
      logic [3:0]  red;
      logic [3:0]  green;
      logic [3:0]  blu;
      logic [3:0]  peak;
      logic [10:0] advanced;
      out_item_t   pt;
      x_axis = {x_high, xy_low[3:0]};
      y_axis = {y_high, xy_low[7:4]};
      red    = red_green[7:4];
      green  = red_green[3:0];
      blu    = blue[7:4];
      if (monochrome) begin
        peak = red;
        if (green > peak) peak = green;
        if (blu > peak) peak = blu;
        red   = peak;
        green = peak;
        blu   = peak;
      end
      // The LED looks at the advanced count before it wraps back to zero.
      advanced = {1'b0, point_count} + 11'd1;
      pt.status_led = (advanced < LED_ON_POINTS);
      if (advanced > LED_PERIOD) begin
        point_count = '0;
        wraps++;
      end else begin
        point_count = advanced[9:0];
      end
      pt.dac_a_word        = {DAC_A_CMD, swap_axes ? x_axis : y_axis};
      pt.dac_b_word        = {DAC_B_CMD, swap_axes ? y_axis : x_axis};
      pt.color_first_byte  = {blu != 4'd0, green != 4'd0, red != 4'd0, blu};
      pt.color_second_byte = {green, red};
      pending_points.push_back(pt);
      points++;
    endfunction

    function void note_byte(in_item_t it);
      phase_t upcoming;
      upcoming = PH_CMD;
      case (phase)
        PH_X: begin
          x_high   = it.data_byte;
          upcoming = PH_Y;
        end
        PH_Y: begin
          y_high   = it.data_byte;
          upcoming = PH_LOW;
        end
        PH_LOW: begin
          xy_low = it.data_byte;
          if (hold_colors) push_point();
          else upcoming = PH_RG;
        end
        PH_RG: begin
          red_green = it.data_byte;
          upcoming  = PH_BLUE;
        end
        PH_BLUE: begin
          blue = it.data_byte;
          push_point();
        end
        default: begin
          if (it.data_byte == CMD_POINT_COLOR || it.data_byte == CMD_POINT_HOLD) begin
            hold_colors = (it.data_byte == CMD_POINT_HOLD);
            upcoming    = PH_X;
          end
        end
      endcase
      // A frame end drops any partial point and returns to command position.
      phase = it.frame_end ? PH_CMD : upcoming;
    endfunction

    function string show(out_item_t pt);
      return $sformatf("a=%04h b=%04h c1=%02h c2=%02h led=%0b", pt.dac_a_word,
                       pt.dac_b_word, pt.color_first_byte, pt.color_second_byte,
                       pt.status_led);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      string     diff;
      if (pending_points.size() == 0) begin
        fail($sformatf("unexpected point %s", show(got)));
        return;
      end
      exp  = pending_points.pop_front();
      diff = "";
      if (got.dac_a_word !== exp.dac_a_word) diff = {diff, " dac_a_word"};
      if (got.dac_b_word !== exp.dac_b_word) diff = {diff, " dac_b_word"};
      if (got.color_first_byte !== exp.color_first_byte) diff = {diff, " color_first_byte"};
      if (got.color_second_byte !== exp.color_second_byte)
        diff = {diff, " color_second_byte"};
      if (got.status_led !== exp.status_led) diff = {diff, " status_led"};
      if (diff != "")
        fail($sformatf("point %0d:%s differ, expected %s, got %s", checked, diff,
                       show(exp), show(got)));
      checked++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data = 1'b0;

  logic             calm = 1'b0;
  int               stream_bytes = 0;
  int               settings_used = 0;
  point_scoreboard  sb = new();

  laser_point_stream_decoder_core #(
    .LED_ON_POINTS(LED_ON_POINTS),
    .LED_PERIOD   (LED_PERIOD)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("laser_point_stream_decoder_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_byte(logic [7:0] value, logic last);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 24) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, frame_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets the stream run dry, then gives the last byte time to leave the parser.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic mono, logic swap);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MONOCHROME;
    cfg_data  <= mono;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_SWAP_AXES;
    cfg_data  <= swap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Zero nibbles are made common so that the color presence bits drop often.
  function automatic logic [3:0] color_nibble();
    return ($urandom_range(99) < 25) ? 4'd0 : 4'($urandom_range(15));
  endfunction

  task automatic random_point();
    logic [7:0] seq [6];
    int         len;
    int         cut;
    int         roll;
    seq[0] = ($urandom_range(99) < 65) ? CMD_POINT_HOLD : CMD_POINT_COLOR;
    seq[1] = 8'($urandom);
    seq[2] = 8'($urandom);
    seq[3] = 8'($urandom);
    seq[4] = {color_nibble(), color_nibble()};
    seq[5] = {color_nibble(), 4'($urandom_range(15))};
    len    = (seq[0] == CMD_POINT_HOLD) ? 4 : 6;
    cut    = -1;
    roll   = $urandom_range(99);
    if (roll < 6) cut = $urandom_range(len - 2);
    else if (roll < 18) cut = len - 1;
    else if (roll < 22) len = $urandom_range(len - 1, 1);
    for (int i = 0; i < len; i++) begin
      send_byte(seq[i], i == cut);
      stream_bytes++;
    end
  endtask

  initial begin
    int phase_no;
    int phase_bytes;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points with the registers still at their reset values.
    send_byte(CMD_POINT_HOLD, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(CMD_POINT_COLOR, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(CMD_POINT_COLOR, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF7, 1'b1);
    send_byte(CMD_POINT_HOLD, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(CMD_POINT_COLOR, 1'b1);
    send_byte(CMD_POINT_HOLD, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h69, 1'b0);
    stream_bytes += 27;
    drain();

    // Random streams under each register setting, one of them without idling.
    phase_no = 0;
    while (stream_bytes < 1300) begin
      program_regs(phase_no[0] ^ phase_no[2], phase_no[1]);
      calm        = (phase_no == 2);
      phase_bytes = 0;
      while (phase_bytes < 260) begin
        if ($urandom_range(99) < 8) begin
          send_byte(8'($urandom), $urandom_range(7) == 0);
          stream_bytes++;
          phase_bytes++;
        end else begin
          phase_bytes -= stream_bytes;
          random_point();
          phase_bytes += stream_bytes;
        end
      end
      drain();
      phase_no++;
    end
    calm = 1'b0;
    program_regs(1'b0, 1'b0);
    drain();

    $display("Summary: %0d stream bytes, %0d points checked, %0d register settings.",
             stream_bytes, sb.checked, settings_used);
    $display("Summary: point counter wrapped %0d times, %0d failures.", sb.wraps,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("laser_point_stream_decoder_core verification clean");
    end else begin
      $display("laser_point_stream_decoder_core verification failed");
    end
    $finish;
  end

endmodule
